// ----- sv/pplt_pkg.sv -----
`default_nettype none

package pplt_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int FACTOR_W = 6;
    localparam int DECAY_SHIFT = 6;

    localparam logic [FACTOR_W-1:0] LR_DECAY = 6'd63;
    localparam logic [FACTOR_W-1:0] BUMPER_DECAY = 6'd61;

    localparam logic [SAMPLE_W-1:0] BAR_LEVEL_LOW = 10'd20;
    localparam logic [SAMPLE_W-1:0] LR_BAR_LEVEL_1 = 10'd100;
    localparam logic [SAMPLE_W-1:0] LR_BAR_LEVEL_2 = 10'd200;
    localparam logic [SAMPLE_W-1:0] LR_BAR_LEVEL_3 = 10'd250;
    localparam logic [SAMPLE_W-1:0] BUMPER_BAR_LEVEL_1 = 10'd50;
    localparam logic [SAMPLE_W-1:0] BUMPER_BAR_LEVEL_2 = 10'd155;

    // 200 mV and 1000 mV on a 5 V, 10-bit converter scale
    localparam logic SOFT_GATE_ENABLE_RST = 1'b1;
    localparam logic [SAMPLE_W-1:0] LIFT_LIMIT_RST = 10'd250;
    localparam logic [SAMPLE_W-1:0] NEAR_LEVEL_RST = 10'd40;
    localparam logic [SAMPLE_W-1:0] FAR_LEVEL_RST = 10'd204;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIFT_GATE_ENABLE = 2'd0,
        CFG_LIFT_LIMIT       = 2'd1,
        CFG_NEAR_LEVEL       = 2'd2,
        CFG_FAR_LEVEL        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
        logic [SAMPLE_W-1:0] bumper_sample;
        logic [SAMPLE_W-1:0] lift_position;
    } in_item_t;

    typedef struct packed {
        logic [3:0]          left_bar;
        logic [3:0]          right_bar;
        logic [2:0]          bumper_bar;
        logic                left_near;
        logic                left_far;
        logic                right_near;
        logic                right_far;
        logic [SAMPLE_W-1:0] left_peak_out;
        logic [SAMPLE_W-1:0] right_peak_out;
        logic [SAMPLE_W-1:0] bumper_peak_out;
    } out_item_t;

    // New peak: take the sample if above, else decay by factor/64
    function automatic logic [SAMPLE_W-1:0] track(
        input logic [SAMPLE_W-1:0] peak,
        input logic [SAMPLE_W-1:0] sample,
        input logic [FACTOR_W-1:0] factor
    );
        logic [SAMPLE_W+FACTOR_W-1:0] prod;
        prod = {{FACTOR_W{1'b0}}, peak} * {{SAMPLE_W{1'b0}}, factor};
        if (sample > peak) begin
            return sample;
        end
        return prod[SAMPLE_W+FACTOR_W-1:DECAY_SHIFT];
    endfunction

    function automatic logic [3:0] lr_bar(input logic [SAMPLE_W-1:0] p);
        return {p > LR_BAR_LEVEL_3, p > LR_BAR_LEVEL_2,
                p > LR_BAR_LEVEL_1, p > BAR_LEVEL_LOW};
    endfunction

    function automatic logic [2:0] bumper_bar(input logic [SAMPLE_W-1:0] p);
        return {p > BUMPER_BAR_LEVEL_2, p > BUMPER_BAR_LEVEL_1, p > BAR_LEVEL_LOW};
    endfunction

endpackage

`default_nettype wire

// ----- sv/proximity_peak_level_tracker_top.sv -----
// Proximity peak level tracker.
// Input channel (s_valid/s_ready/s_data): one sample set per transfer, holding
// left, right and bumper proximity readings and the lift position.
// Result channel (m_valid/m_ready/m_data): one result per input transfer, in
// order: level bars of the updated peaks, near/far flags on the gated left and
// right samples, and the three updated peaks.
// Config port (cfg_wr_en/cfg_index/cfg_wdata): write-only, one register per
// cycle, no wait; write it only while no sample set is in flight.
// Path: a set taken goes through the input register, then the result
// register, which drives m_data. Throughput: one set per cycle while the
// receiver takes results; the peak registers update in the same cycle the
// result register loads.
// Reset (aresetn low, synchronous): peaks clear to zero, registers go to their
// defaults (gating on, lift limit 250, near 40, far 204), both stages empty.
// Receiver stall: the result holds on m_data; the input register still takes
// one more set, then s_ready drops until the result is taken.
`default_nettype none

module proximity_peak_level_tracker_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire pplt_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output pplt_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pplt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pplt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic                            gate_en_reg;
    logic [pplt_pkg::SAMPLE_W-1:0]   lift_limit_reg;
    logic [pplt_pkg::SAMPLE_W-1:0]   near_level_reg;
    logic [pplt_pkg::SAMPLE_W-1:0]   far_level_reg;

    logic                            in_valid_reg;
    pplt_pkg::in_item_t              in_reg;
    logic                            out_valid_reg;
    pplt_pkg::out_item_t             out_reg;
    pplt_pkg::out_item_t             out_next;

    logic [pplt_pkg::SAMPLE_W-1:0]   left_peak_reg;
    logic [pplt_pkg::SAMPLE_W-1:0]   right_peak_reg;
    logic [pplt_pkg::SAMPLE_W-1:0]   bumper_peak_reg;
    logic [pplt_pkg::SAMPLE_W-1:0]   left_peak_next;
    logic [pplt_pkg::SAMPLE_W-1:0]   right_peak_next;
    logic [pplt_pkg::SAMPLE_W-1:0]   bumper_peak_next;

    logic [pplt_pkg::SAMPLE_W-1:0]   left_gated;
    logic [pplt_pkg::SAMPLE_W-1:0]   right_gated;
    logic                            blank;
    logic                            advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_en_reg    <= pplt_pkg::SOFT_GATE_ENABLE_RST;
            lift_limit_reg <= pplt_pkg::LIFT_LIMIT_RST;
            near_level_reg <= pplt_pkg::NEAR_LEVEL_RST;
            far_level_reg  <= pplt_pkg::FAR_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (pplt_pkg::cfg_index_t'(cfg_index))
                pplt_pkg::CFG_LIFT_GATE_ENABLE: begin
                    gate_en_reg <= cfg_wdata[0];
                end
                pplt_pkg::CFG_LIFT_LIMIT: begin
                    lift_limit_reg <= cfg_wdata[pplt_pkg::SAMPLE_W-1:0];
                end
                pplt_pkg::CFG_NEAR_LEVEL: begin
                    near_level_reg <= cfg_wdata[pplt_pkg::SAMPLE_W-1:0];
                end
                pplt_pkg::CFG_FAR_LEVEL: begin
                    far_level_reg <= cfg_wdata[pplt_pkg::SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        blank       = gate_en_reg && (in_reg.lift_position < lift_limit_reg);
        left_gated  = blank ? '0 : in_reg.left_sample;
        right_gated = blank ? '0 : in_reg.right_sample;

        left_peak_next   = pplt_pkg::track(left_peak_reg, left_gated, pplt_pkg::LR_DECAY);
        right_peak_next  = pplt_pkg::track(right_peak_reg, right_gated, pplt_pkg::LR_DECAY);
        bumper_peak_next = pplt_pkg::track(bumper_peak_reg, in_reg.bumper_sample,
                                           pplt_pkg::BUMPER_DECAY);

        out_next.left_bar        = pplt_pkg::lr_bar(left_peak_next);
        out_next.right_bar       = pplt_pkg::lr_bar(right_peak_next);
        out_next.bumper_bar      = pplt_pkg::bumper_bar(bumper_peak_next);
        out_next.left_near       = left_gated > near_level_reg;
        out_next.left_far        = left_gated > far_level_reg;
        out_next.right_near      = right_gated > near_level_reg;
        out_next.right_far       = right_gated > far_level_reg;
        out_next.left_peak_out   = left_peak_next;
        out_next.right_peak_out  = right_peak_next;
        out_next.bumper_peak_out = bumper_peak_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_peak_reg   <= '0;
            right_peak_reg  <= '0;
            bumper_peak_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                left_peak_reg   <= left_peak_next;
                right_peak_reg  <= right_peak_next;
                bumper_peak_reg <= bumper_peak_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load on transfer, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Peaks update only together with the result register
    a_peak_matches_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.left_peak_out == left_peak_reg
                           && out_reg.right_peak_out == right_peak_reg
                           && out_reg.bumper_peak_out == bumper_peak_reg))
        else $error("result peaks differ from peak state");

    a_bar_matches_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.left_bar == pplt_pkg::lr_bar(left_peak_reg)
                           && out_reg.bumper_bar == pplt_pkg::bumper_bar(bumper_peak_reg)))
        else $error("level bar does not match peak");

    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register empty after advance");

endmodule

`default_nettype wire
